[hdl/dlps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and per-item functions of the dual LED pulse sequencer.
package dlps_pkg;

	localparam int STEPS_PER_PERIOD = 100;
	localparam int PHASE_OFFSET     = 50;
	localparam int INITIAL_DUTY     = 384;

	localparam int STEP_W   = 7;
	localparam int DUTY_W   = 11;
	localparam int THR_W    = 12;
	localparam int CMD_W    = 2;
	localparam int REG_IDX_W = 3;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [DUTY_W-1:0] duty_t;
	typedef logic [THR_W-1:0]  thr_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_IR   = 2'd1,
		CMD_RED  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_LOW_THR    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_THR   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_HI    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_LO    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ENVELOPE   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CONVERT    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_GATE_FIRST = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_GATE_LAST  = 3'd7;

	typedef struct packed {
		thr_t  low_thr;
		thr_t  high_thr;
		duty_t duty_hi;
		duty_t duty_lo;
		step_t envelope;
		step_t convert;
		step_t gate_first;
		step_t gate_last;
	} cfg_t;

	typedef struct packed {
		logic  led;
		logic  gate;
		duty_t cmp;
		logic  cnv;
	} chan_res_t;

	typedef struct packed {
		chan_res_t ir;
		chan_res_t red;
		duty_t     ir_duty;
		duty_t     red_duty;
	} result_t;

	// step counter advance with wrap at the period length
	function automatic step_t step_advance(input step_t s);
		logic [STEP_W:0] n;
		n = {1'b0, s} + (STEP_W+1)'(1);
		if (n >= (STEP_W+1)'(STEPS_PER_PERIOD)) begin
			n = '0;
		end
		return n[STEP_W-1:0];
	endfunction

	// one-count duty nudge; the fall test sees the risen value
	function automatic duty_t duty_adjust(input duty_t duty, input thr_t reading,
			input cfg_t cfg);
		duty_t d;
		d = duty;
		if (reading < cfg.low_thr && d < cfg.duty_hi) begin
			d = d + duty_t'(1);
		end
		if (reading > cfg.high_thr && d > cfg.duty_lo) begin
			d = d - duty_t'(1);
		end
		return d;
	endfunction

	function automatic chan_res_t chan_eval(input step_t step, input duty_t duty,
			input logic active, input logic tick, input cfg_t cfg);
		chan_res_t r;
		logic      in_env;
		in_env = active && (step <= cfg.envelope);
		r.led  = in_env;
		r.gate = in_env && (step >= cfg.gate_first) && (step <= cfg.gate_last);
		r.cmp  = (active && (step < cfg.envelope)) ? duty : '0;
		r.cnv  = tick && in_env && (step == cfg.convert);
		return r;
	endfunction

endpackage

[hdl/dlps_cfg.sv]
`timescale 1ns / 1ps
// APB register file holding the sequencer and intensity control settings.
module dlps_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output dlps_pkg::cfg_t  cfg
);
	import dlps_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_thr    <= thr_t'(2500);
			cfg_q.high_thr   <= thr_t'(2600);
			cfg_q.duty_hi    <= duty_t'(1151);
			cfg_q.duty_lo    <= duty_t'(64);
			cfg_q.envelope   <= step_t'(25);
			cfg_q.convert    <= step_t'(13);
			cfg_q.gate_first <= step_t'(5);
			cfg_q.gate_last  <= step_t'(15);
		end else if (wr_en) begin
			case (idx)
				REG_LOW_THR:    cfg_q.low_thr    <= pwdata[THR_W-1:0];
				REG_HIGH_THR:   cfg_q.high_thr   <= pwdata[THR_W-1:0];
				REG_DUTY_HI:    cfg_q.duty_hi    <= pwdata[DUTY_W-1:0];
				REG_DUTY_LO:    cfg_q.duty_lo    <= pwdata[DUTY_W-1:0];
				REG_ENVELOPE:   cfg_q.envelope   <= pwdata[STEP_W-1:0];
				REG_CONVERT:    cfg_q.convert    <= pwdata[STEP_W-1:0];
				REG_GATE_FIRST: cfg_q.gate_first <= pwdata[STEP_W-1:0];
				REG_GATE_LAST:  cfg_q.gate_last  <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LOW_THR:    prdata = 32'(cfg_q.low_thr);
			REG_HIGH_THR:   prdata = 32'(cfg_q.high_thr);
			REG_DUTY_HI:    prdata = 32'(cfg_q.duty_hi);
			REG_DUTY_LO:    prdata = 32'(cfg_q.duty_lo);
			REG_ENVELOPE:   prdata = 32'(cfg_q.envelope);
			REG_CONVERT:    prdata = 32'(cfg_q.convert);
			REG_GATE_FIRST: prdata = 32'(cfg_q.gate_first);
			REG_GATE_LAST:  prdata = 32'(cfg_q.gate_last);
			default:        prdata = '0;
		endcase
	end

endmodule

[hdl/dlps_core.sv]
`timescale 1ns / 1ps
// Step counters, duty registers and the registered result word.
module dlps_core (
	input  logic               clk,
	input  logic               arst_n,
	input  dlps_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  dlps_pkg::cmd_t     in_cmd,
	input  dlps_pkg::thr_t     in_reading,
	output logic               out_valid,
	input  logic               out_ready,
	output dlps_pkg::result_t  out_res
);
	import dlps_pkg::*;

	step_t   ir_step_q, red_step_q, ir_step_d, red_step_d;
	logic    red_started_q, red_started_d;
	duty_t   ir_duty_q, red_duty_q, ir_duty_d, red_duty_d;
	logic    res_valid_q;
	result_t res_q, res_d;
	logic    tick;
	logic    acc;

	// result register frees up in the same cycle it is taken
	assign in_ready  = !res_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign tick      = (in_cmd == CMD_TICK);
	assign out_valid = res_valid_q;
	assign out_res   = res_q;

	always_comb begin
		ir_step_d     = ir_step_q;
		red_step_d    = red_step_q;
		red_started_d = red_started_q;
		ir_duty_d     = ir_duty_q;
		red_duty_d    = red_duty_q;
		case (in_cmd)
			CMD_TICK: begin
				ir_step_d = step_advance(ir_step_q);
				if (ir_step_d == step_t'(PHASE_OFFSET)) begin
					red_started_d = 1'b1;
				end
				if (red_started_d) begin
					red_step_d = step_advance(red_step_q);
				end
			end
			CMD_IR:  ir_duty_d  = duty_adjust(ir_duty_q, in_reading, cfg);
			CMD_RED: red_duty_d = duty_adjust(red_duty_q, in_reading, cfg);
			default: ;
		endcase
		res_d.ir       = chan_eval(ir_step_d, ir_duty_d, 1'b1, tick, cfg);
		res_d.red      = chan_eval(red_step_d, red_duty_d, red_started_d, tick, cfg);
		res_d.ir_duty  = ir_duty_d;
		res_d.red_duty = red_duty_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_step_q     <= '0;
			red_step_q    <= '0;
			red_started_q <= 1'b0;
			ir_duty_q     <= duty_t'(INITIAL_DUTY);
			red_duty_q    <= duty_t'(INITIAL_DUTY);
			res_valid_q   <= 1'b0;
		end else begin
			if (acc) begin
				ir_step_q     <= ir_step_d;
				red_step_q    <= red_step_d;
				red_started_q <= red_started_d;
				ir_duty_q     <= ir_duty_d;
				red_duty_q    <= red_duty_d;
				res_valid_q   <= 1'b1;
			end else if (out_ready) begin
				res_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_d;
		end
	end

`ifndef ASSERT_OFF
	a_red_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!red_started_q |-> (red_step_q == '0))
		else $error("red step moved before red start");

	a_ir_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		ir_step_q < step_t'(STEPS_PER_PERIOD))
		else $error("IR step beyond period");

	a_sample_holds_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !tick) |=> ($stable(ir_step_q) && $stable(red_step_q)))
		else $error("sample word moved a step counter");

	a_ir_duty_slew: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (ir_duty_q == $past(ir_duty_q)
			|| ir_duty_q == $past(ir_duty_q) + duty_t'(1)
			|| ir_duty_q == $past(ir_duty_q) - duty_t'(1)))
		else $error("IR duty moved by more than one");

	a_tick_holds_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && tick) |=> ($stable(ir_duty_q) && $stable(red_duty_q)))
		else $error("tick word changed a duty");
`endif

endmodule

[hdl/dual_led_pulse_sequencer_agc.sv]
`timescale 1ns / 1ps
// Top level of the dual LED pulse sequencer with LED intensity control.
//
//  channel   dir   handshake                 payload
//  s_axis    in    tvalid/tready             tuser = cmd, tdata = DC reading
//  m_axis    out   tvalid/tready             tdata = LED, gate, compare, convert, duty
//  apb       in    psel/penable/pwrite/pready  8 x 32-bit registers at 4*index
//
// One word per clock: a word accepted at an edge has its result word on m_axis
// from the next cycle. The result register is refilled in the same cycle it is
// taken, so s_axis_tready only drops while a result waits with m_axis_tready low.
// Reset (arst_n low) clears both step counters and the red start flag, loads
// both duties with 384 and the registers with their defaults; no pass is needed.
// The whole item update (counter wrap, duty nudge, window compares) sits between
// the state registers and the result register.
module dual_led_pulse_sequencer_agc (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [11:0] sample_value, [15:12] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] ir_led_on, [1] red_led_on, [2] ir_gate_on, [3] red_gate_on,
	// [14:4] ir_compare, [25:15] red_compare, [26] ir_convert, [27] red_convert,
	// [38:28] ir_duty_now, [49:39] red_duty_now, [55:50] zero
	output logic [55:0] m_axis_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dlps_pkg::*;

	cfg_t    cfg;
	result_t res;
	cmd_t    cmd;

	assign cmd = cmd_t'(s_axis_tuser);

	dlps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dlps_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (cmd),
		.in_reading (s_axis_tdata[THR_W-1:0]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	// pack the result word, ir_led_on in the low bit
	assign m_axis_tdata = {6'b0,
		res.red_duty, res.ir_duty,
		res.red.cnv, res.ir.cnv,
		res.red.cmp, res.ir.cmp,
		res.red.gate, res.ir.gate,
		res.red.led, res.ir.led};

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the dual LED pulse sequencer: streamed ticks and samples, APB setup.
module tb_top;
	import dlps_pkg::*;

	// Watchdog: cycles in a row with no accepted word on either stream and no
	// register write. The slowest legal stretch (51 percent gaps on one side at a time)
	// stays far below this.
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int NUM_PHASES       = 5;
	localparam int NUM_REGS         = 8;
	localparam int MAX_REPORTS      = 10;
	// cycles left after the last result: the block has one result register
	localparam int DRAIN_CYCLES     = 5;

	localparam cfg_t CFG_AFTER_RESET = '{low_thr: 12'd2500, high_thr: 12'd2600,
		duty_hi: 11'd1151, duty_lo: 11'd64, envelope: 7'd25, convert: 7'd13,
		gate_first: 7'd5, gate_last: 7'd15};

	// Result word as it sits on m_axis_tdata, top bits first.
	typedef struct packed {
		logic [5:0] pad;
		duty_t      red_duty;
		duty_t      ir_duty;
		logic       red_cnv;
		logic       ir_cnv;
		duty_t      red_cmp;
		duty_t      ir_cmp;
		logic       red_gate;
		logic       ir_gate;
		logic       red_led;
		logic       ir_led;
	} led_word_t;

	typedef struct {
		cmd_t cmd;
		thr_t reading;
	} stim_item_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata   = '0;   // [11:0] sample_value, [15:12] zero
	logic [1:0]  s_axis_tuser   = '0;   // [1:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	// [0] ir_led_on, [1] red_led_on, [2] ir_gate_on, [3] red_gate_on,
	// [14:4] ir_compare, [25:15] red_compare, [26] ir_convert, [27] red_convert,
	// [38:28] ir_duty_now, [49:39] red_duty_now, [55:50] zero
	logic [55:0] m_axis_tdata;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [4:0]  paddr          = '0;
	logic [31:0] pwdata         = '0;
	logic [31:0] prdata;
	logic        pready;

	dual_led_pulse_sequencer_agc i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow of the sequencer: register copy plus counters and duties.
	cfg_t  cfg_mirror = CFG_AFTER_RESET;
	step_t ir_step     = '0;
	step_t red_step    = '0;
	logic  red_started = 1'b0;
	duty_t ir_duty     = duty_t'(INITIAL_DUTY);
	duty_t red_duty    = duty_t'(INITIAL_DUTY);

	stim_item_t stim_items[$];      // words waiting for the driver
	led_word_t  expected_words[$];  // predicted results, oldest first

	logic in_taken       = 1'b0;    // input word accepted at the last edge
	int   sender_idle_pct = 0;
	int   recv_stall_pct  = 0;
	int   stall_cycles    = 0;
	int   mismatches      = 0;
	int   words_checked   = 0;
	int   tick_count      = 0;
	int   sample_count    = 0;
	int   unused_count    = 0;
	int   convert_pulses  = 0;

	function automatic step_t next_step(input step_t s);
		logic [STEP_W:0] n;
		n = {1'b0, s} + 1'b1;
		if (n >= (STEP_W+1)'(STEPS_PER_PERIOD)) begin
			n = '0;
		end
		return n[STEP_W-1:0];
	endfunction

	// Raise first, then the lower test sees the raised value.
	function automatic duty_t nudge_duty(input duty_t d, input thr_t reading);
		duty_t v;
		v = d;
		if (reading < cfg_mirror.low_thr && v < cfg_mirror.duty_hi) begin
			v = v + 1'b1;
		end
		if (reading > cfg_mirror.high_thr && v > cfg_mirror.duty_lo) begin
			v = v - 1'b1;
		end
		return v;
	endfunction

	function automatic chan_res_t eval_channel(input step_t step, input duty_t duty,
			input logic active, input logic tick);
		chan_res_t r;
		logic      in_env;
		in_env = active && (step <= cfg_mirror.envelope);
		r.led  = in_env;
		r.gate = in_env && (step >= cfg_mirror.gate_first) && (step <= cfg_mirror.gate_last);
		r.cmp  = (active && (step < cfg_mirror.envelope)) ? duty : '0;
		r.cnv  = tick && in_env && (step == cfg_mirror.convert);
		return r;
	endfunction

	// Applies one input word to the shadow state and returns the result word.
	function automatic led_word_t predict_led_word(input cmd_t cmd, input thr_t reading);
		led_word_t w;
		chan_res_t ir_r;
		chan_res_t red_r;
		logic      tick;
		tick = (cmd == CMD_TICK);
		case (cmd)
			CMD_TICK: begin
				ir_step = next_step(ir_step);
				if (ir_step == step_t'(PHASE_OFFSET)) begin
					red_started = 1'b1;
				end
				if (red_started) begin
					red_step = next_step(red_step);
				end
				tick_count++;
			end
			CMD_IR: begin
				ir_duty = nudge_duty(ir_duty, reading);
				sample_count++;
			end
			CMD_RED: begin
				red_duty = nudge_duty(red_duty, reading);
				sample_count++;
			end
			default: begin
				unused_count++;
			end
		endcase
		ir_r  = eval_channel(ir_step, ir_duty, 1'b1, tick);
		red_r = eval_channel(red_step, red_duty, red_started, tick);
		w = '0;
		w.ir_led   = ir_r.led;
		w.red_led  = red_r.led;
		w.ir_gate  = ir_r.gate;
		w.red_gate = red_r.gate;
		w.ir_cmp   = ir_r.cmp;
		w.red_cmp  = red_r.cmp;
		w.ir_cnv   = ir_r.cnv;
		w.red_cnv  = red_r.cnv;
		w.ir_duty  = ir_duty;
		w.red_duty = red_duty;
		convert_pulses += ir_r.cnv + red_r.cnv;
		return w;
	endfunction

	// Mostly ticks so both counters sweep their periods; readings cluster
	// around the thresholds so the hysteresis edges get hit often.
	function automatic stim_item_t random_item();
		stim_item_t it;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			it.cmd = CMD_TICK;
		end else if (pick < 82) begin
			it.cmd = CMD_IR;
		end else if (pick < 94) begin
			it.cmd = CMD_RED;
		end else begin
			it.cmd = CMD_NONE;
		end
		case ($urandom_range(3))
			0: it.reading = cfg_mirror.low_thr + thr_t'($urandom_range(4)) - thr_t'(2);
			1: it.reading = cfg_mirror.high_thr + thr_t'($urandom_range(4)) - thr_t'(2);
			default: it.reading = thr_t'($urandom());
		endcase
		return it;
	endfunction

	// APB write: setup cycle, access cycle, then the shadow copy follows at
	// the edge where the block takes the value.
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LOW_THR:    cfg_mirror.low_thr    = value[THR_W-1:0];
			REG_HIGH_THR:   cfg_mirror.high_thr   = value[THR_W-1:0];
			REG_DUTY_HI:    cfg_mirror.duty_hi    = value[DUTY_W-1:0];
			REG_DUTY_LO:    cfg_mirror.duty_lo    = value[DUTY_W-1:0];
			REG_ENVELOPE:   cfg_mirror.envelope   = value[STEP_W-1:0];
			REG_CONVERT:    cfg_mirror.convert    = value[STEP_W-1:0];
			REG_GATE_FIRST: cfg_mirror.gate_first = value[STEP_W-1:0];
			REG_GATE_LAST:  cfg_mirror.gate_last  = value[STEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Register settings per phase, in register index order.
	task automatic load_setting(input int phase);
		logic [31:0] vals [NUM_REGS];
		case (phase)
			// crossed thresholds, widest limits, envelope and gate over the whole period
			1: vals = '{32'd4095, 32'd0, 32'd2047, 32'd0, 32'd127, 32'd0, 32'd0, 32'd127};
			// equal thresholds, tight limits around the start duty, empty gate window, envelope only at step 0
			2: vals = '{32'd2048, 32'd2048, 32'd386, 32'd382, 32'd0, 32'd99, 32'd99, 32'd0};
			// anything, upper bus bits included
			3: vals = '{$urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom()};
			// both tests pass on readings 1 to 4094 but the limits block any move
			default: vals = '{32'd4095, 32'd0, 32'd0, 32'd1279, 32'd99, 32'd99, 32'd0, 32'd99};
		endcase
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_write(REG_IDX_W'(i), vals[i]);
		end
	endtask

	// Idle means: nothing queued, nothing offered, nothing outstanding.
	// Checked just after the rising edge, once all edge updates have settled.
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (stim_items.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
	endtask

	// Driver: offers the next queued word at the falling edge, holds it until
	// taken, and throttles both sides by the current percentages.
	always @(negedge clk) begin : drive_stream
		stim_item_t item;
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (stim_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					item = stim_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'b0000, item.reading};
					s_axis_tuser  <= item.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: at each rising edge, a taken result is checked against the
	// oldest prediction first, then a taken input word adds its prediction.
	always @(posedge clk) begin : check_results
		led_word_t got;
		led_word_t want;
		string     bad;
		logic      activity;
		if (arst_n) begin
			activity = 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				activity = 1'b1;
				got = led_word_t'(m_axis_tdata);
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected result word %h, none predicted", got);
					end
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					bad = "";
					if (got.ir_led !== want.ir_led)
						bad = {bad, $sformatf(" ir_led_on %0b/%0b", want.ir_led, got.ir_led)};
					if (got.red_led !== want.red_led)
						bad = {bad, $sformatf(" red_led_on %0b/%0b", want.red_led, got.red_led)};
					if (got.ir_gate !== want.ir_gate)
						bad = {bad, $sformatf(" ir_gate_on %0b/%0b", want.ir_gate, got.ir_gate)};
					if (got.red_gate !== want.red_gate)
						bad = {bad, $sformatf(" red_gate_on %0b/%0b", want.red_gate, got.red_gate)};
					if (got.ir_cmp !== want.ir_cmp)
						bad = {bad, $sformatf(" ir_compare %0d/%0d", want.ir_cmp, got.ir_cmp)};
					if (got.red_cmp !== want.red_cmp)
						bad = {bad, $sformatf(" red_compare %0d/%0d", want.red_cmp, got.red_cmp)};
					if (got.ir_cnv !== want.ir_cnv)
						bad = {bad, $sformatf(" ir_convert %0b/%0b", want.ir_cnv, got.ir_cnv)};
					if (got.red_cnv !== want.red_cnv)
						bad = {bad, $sformatf(" red_convert %0b/%0b", want.red_cnv, got.red_cnv)};
					if (got.ir_duty !== want.ir_duty)
						bad = {bad, $sformatf(" ir_duty_now %0d/%0d", want.ir_duty, got.ir_duty)};
					if (got.red_duty !== want.red_duty)
						bad = {bad, $sformatf(" red_duty_now %0d/%0d", want.red_duty, got.red_duty)};
					if (bad != "") begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("result word %0d wrong (expected/actual):%s",
								words_checked, bad);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				activity = 1'b1;
				expected_words.push_back(predict_led_word(cmd_t'(s_axis_tuser),
					s_axis_tdata[THR_W-1:0]));
			end
			if (psel && penable && pwrite && pready) begin
				activity = 1'b1;
			end
			in_taken <= s_axis_tvalid && s_axis_tready;
			stall_cycles = activity ? 0 : stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without progress, %0d results outstanding",
					stall_cycles, expected_words.size());
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Run plan: reset once, then five phases, each with its own register
	// setting; phases 1 to 3 each add their own idle pattern. Phase 0 runs
	// on the reset values and opens with directed words; the rest is random.
	initial begin : run_sequence
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				1: begin sender_idle_pct <= 51; recv_stall_pct <= 0;  end
				2: begin sender_idle_pct <= 0;  recv_stall_pct <= 51; end
				3: begin sender_idle_pct <= 7;  recv_stall_pct <= 7;  end
				default: begin sender_idle_pct <= 0; recv_stall_pct <= 0; end
			endcase
			if (phase > 0) begin
				load_setting(phase);
			end
			@(posedge clk);
			if (phase == 0) begin
				// red channel still parked here; readings on both sides of each
				// threshold, the field extremes and the unused command
				stim_items.push_back('{CMD_TICK, 12'd4095});
				stim_items.push_back('{CMD_IR, 12'd2499});
				stim_items.push_back('{CMD_IR, 12'd2500});
				stim_items.push_back('{CMD_IR, 12'd2600});
				stim_items.push_back('{CMD_IR, 12'd2601});
				stim_items.push_back('{CMD_IR, 12'd0});
				stim_items.push_back('{CMD_IR, 12'd4095});
				stim_items.push_back('{CMD_RED, 12'd0});
				stim_items.push_back('{CMD_RED, 12'd4095});
				stim_items.push_back('{CMD_RED, 12'd2499});
				stim_items.push_back('{CMD_RED, 12'd2601});
				stim_items.push_back('{CMD_NONE, 12'd4095});
				stim_items.push_back('{CMD_NONE, 12'd0});
				stim_items.push_back('{CMD_TICK, 12'd0});
				stim_items.push_back('{CMD_TICK, 12'd2048});
				stim_items.push_back('{CMD_TICK, 12'd1365});
				stim_items.push_back('{CMD_TICK, 12'd2730});
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				stim_items.push_back(random_item());
			end
			wait_idle();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d ticks, %0d samples, %0d unused words; %0d results checked",
			tick_count, sample_count, unused_count, words_checked);
		$display("%0d register settings, %0d convert pulses, red channel started: %0b",
			NUM_PHASES, convert_pulses, red_started);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/dlps_pkg.sv
hdl/dlps_cfg.sv
hdl/dlps_core.sv
hdl/dual_led_pulse_sequencer_agc.sv
bench/tb_top.sv
